/* hw/rtl/lbat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbat_pkg: linked block allocation table definitions
// Sizes, request/result formats, table entry layout and codes shared by the
// table store, the sequencer and the top level.
// ----------------------------------------------------------------------------
package lbat_pkg;

  // table geometry
  localparam int ENTRIES     = 32;
  localparam int BLOCK_BYTES = 256;

  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int LINK_W    = CNT_W;
  localparam int NAME_W    = 8;
  localparam int SIZE_W    = 14;
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int FILL_W    = BLK_SHIFT + 1;
  localparam int REQ_W     = SIZE_W - BLK_SHIFT + 1;

  typedef enum logic [1:0] {
    ACT_FORMAT   = 2'd0,
    ACT_ALLOCATE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_DELETE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_NOSPACE  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP,
    S_ALLOC,
    S_FIND,
    S_WALK
  } state_e;

  // input request
  typedef struct packed {
    action_e             action;
    logic [NAME_W-1:0]   file_name;
    logic [SIZE_W-1:0]   file_size;
  } req_t;

  // one result
  typedef struct packed {
    status_e             status;
    logic [IDX_W-1:0]    block_index;
    logic [IDX_W-1:0]    part_number;
    logic [FILL_W-1:0]   bytes_in_block;
    logic [CNT_W-1:0]    block_count;
    logic [CNT_W-1:0]    free_blocks;
    logic [CNT_W-1:0]    file_total;
    logic                last;
  } res_t;

  // payload of one table entry (the used mark is kept apart)
  typedef struct packed {
    logic [NAME_W-1:0]   name;
    logic [IDX_W-1:0]    part;
    logic [CNT_W-1:0]    blocks;
    logic [LINK_W-1:0]   link;
    logic [FILL_W-1:0]   fill;
  } ent_t;

  localparam ent_t ENT_RESET = '{
    name:   '0,
    part:   '0,
    blocks: '0,
    link:   LINK_W'(ENTRIES),
    fill:   '0
  };

  // table write commands from the sequencer
  typedef struct packed {
    logic                en;
    logic                used;
    logic [IDX_W-1:0]    idx;
    ent_t                data;
    logic                lnk_en;
    logic [IDX_W-1:0]    lnk_idx;
    logic [LINK_W-1:0]   lnk_val;
  } tbl_wr_t;

endpackage
`default_nettype wire

/* hw/rtl/lbat_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbat_table: allocation table store
// One entry per block in flops, one read address, an entry write plus a link
// patch per cycle. Used marks clear at once on reset or format; an entry that
// is not used reads as its reset value.
// ----------------------------------------------------------------------------
module lbat_table (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        clear_i,
  input  lbat_pkg::tbl_wr_t          wr_i,
  input  wire [lbat_pkg::IDX_W-1:0]  rd_idx_i,
  output logic                       rd_used_o,
  output lbat_pkg::ent_t             rd_o
);
  import lbat_pkg::*;

  logic used_q [ENTRIES];
  ent_t ent_q  [ENTRIES];

  // used marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) used_q[i] <= 1'b0;
    end else if (clear_i) begin
      for (int i = 0; i < ENTRIES; i++) used_q[i] <= 1'b0;
    end else if (wr_i.en) begin
      used_q[wr_i.idx] <= wr_i.used;
    end
  end

  // entry payload and link patch of the previous block
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ent_q[wr_i.idx] <= wr_i.data;
    end
    if (wr_i.lnk_en) begin
      ent_q[wr_i.lnk_idx].link <= wr_i.lnk_val;
    end
  end

  // read port, masked to reset values for free entries
  assign rd_used_o = used_q[rd_idx_i];
  assign rd_o      = rd_used_o ? ent_q[rd_idx_i] : ENT_RESET;

endmodule
`default_nettype wire

/* hw/rtl/lbat_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbat_ctrl: table sequencer
// Steps a single entry pointer through the table one entry per cycle: name
// scans, first-fit allocation and chain walks all share the same read port,
// name compare and counters. Results leave through a one-cycle strobe register.
// ----------------------------------------------------------------------------
module lbat_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  lbat_pkg::req_t             req_i,
  output logic                       busy_o,
  output logic                       res_valid_o,
  output lbat_pkg::res_t             res_o,
  output logic                       clear_o,
  output lbat_pkg::tbl_wr_t          wr_o,
  output logic [lbat_pkg::IDX_W-1:0] rd_idx_o,
  input  wire                        rd_used_i,
  input  lbat_pkg::ent_t             rd_i
);
  import lbat_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(ENTRIES);

  state_e             state_q, state_d;
  action_e            act_q, act_d;
  logic [NAME_W-1:0]  name_q, name_d;
  logic [SIZE_W-1:0]  left_q, left_d;
  logic [REQ_W-1:0]   need_q, need_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [IDX_W-1:0]   prev_q, prev_d;
  logic               prev_vld_q, prev_vld_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   freed_q, freed_d;
  logic [CNT_W-1:0]   free_q, free_d;
  logic [CNT_W-1:0]   files_q, files_d;
  res_t               res_q, res_d;
  logic               res_vld_q, res_vld_d;

  // shared helpers
  logic [REQ_W-1:0]   need_raw;
  logic [REQ_W-1:0]   need_new;
  logic [FILL_W-1:0]  fill;
  logic [CNT_W-1:0]   j_inc;
  logic               name_hit;
  logic               walk_stop;
  logic [CNT_W-1:0]   freed_new;
  logic [CNT_W:0]     free_sum;
  logic [CNT_W-1:0]   free_del;
  logic [CNT_W-1:0]   files_del;

  function automatic res_t mk_res(status_e st, logic [IDX_W-1:0] idx,
                                  logic [IDX_W-1:0] part, logic [FILL_W-1:0] bytes,
                                  logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] fr,
                                  logic [CNT_W-1:0] fl, logic lst);
    res_t r;
    r.status         = st;
    r.block_index    = idx;
    r.part_number    = part;
    r.bytes_in_block = bytes;
    r.block_count    = cnt;
    r.free_blocks    = fr;
    r.file_total     = fl;
    r.last           = lst;
    return r;
  endfunction

  // blocks needed: ceiling of size over block bytes, at least one
  assign need_raw = REQ_W'(req_i.file_size[SIZE_W-1:BLK_SHIFT])
                  + REQ_W'(|req_i.file_size[BLK_SHIFT-1:0]);
  assign need_new = (need_raw == '0) ? REQ_W'(1) : need_raw;

  // bytes going into the current block
  assign fill = (left_q >= SIZE_W'(BLOCK_BYTES)) ? FILL_W'(BLOCK_BYTES)
                                                 : FILL_W'(left_q);

  assign j_inc     = j_q + CNT_W'(1);
  assign name_hit  = rd_used_i && (rd_i.name == name_q);
  assign walk_stop = (j_inc >= cnt_q) || (j_inc >= FULL) || (rd_i.link >= LINK_W'(ENTRIES));

  // delete bookkeeping
  assign freed_new = freed_q + CNT_W'(rd_used_i);
  assign free_sum  = {1'b0, free_q} + {1'b0, freed_new};
  assign free_del  = (free_sum > {1'b0, FULL}) ? FULL : free_sum[CNT_W-1:0];
  assign files_del = files_q - CNT_W'(files_q != '0);

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      free_q    <= FULL;
      files_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      free_q    <= free_d;
      files_q   <= files_d;
      res_vld_q <= res_vld_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    name_q     <= name_d;
    left_q     <= left_d;
    need_q     <= need_d;
    cnt_q      <= cnt_d;
    j_q        <= j_d;
    ptr_q      <= ptr_d;
    prev_q     <= prev_d;
    prev_vld_q <= prev_vld_d;
    head_q     <= head_d;
    freed_q    <= freed_d;
    res_q      <= res_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    name_d     = name_q;
    left_d     = left_q;
    need_d     = need_q;
    cnt_d      = cnt_q;
    j_d        = j_q;
    ptr_d      = ptr_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    head_d     = head_q;
    freed_d    = freed_q;
    free_d     = free_q;
    files_d    = files_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    clear_o    = 1'b0;
    wr_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d      = req_i.action;
          name_d     = req_i.file_name;
          left_d     = req_i.file_size;
          need_d     = need_new;
          ptr_d      = '0;
          j_d        = '0;
          prev_vld_d = 1'b0;
          freed_d    = '0;
          case (req_i.action)
            ACT_FORMAT: begin
              clear_o   = 1'b1;
              free_d    = FULL;
              files_d   = '0;
              res_d     = mk_res(ST_OK, '0, '0, '0, '0, FULL, '0, 1'b1);
              res_vld_d = 1'b1;
            end
            ACT_ALLOCATE: state_d = S_DUP;
            ACT_READ, ACT_DELETE: state_d = S_FIND;
            default: state_d = S_IDLE;
          endcase
        end
      end

      // duplicate name scan, then space check
      S_DUP: begin
        if (name_hit) begin
          res_d     = mk_res(ST_EXISTS, '0, '0, '0, '0, free_q, files_q, 1'b1);
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else if (ptr_q == LAST_IDX) begin
          if ((need_q > REQ_W'(free_q)) || (files_q >= FULL)) begin
            res_d     = mk_res(ST_NOSPACE, '0, '0, '0, '0, free_q, files_q, 1'b1);
            res_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else begin
            cnt_d   = CNT_W'(need_q);
            free_d  = free_q - CNT_W'(need_q);
            files_d = files_q + CNT_W'(1);
            ptr_d   = '0;
            state_d = S_ALLOC;
          end
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end

      // first-fit: claim each free entry and link it behind the previous one
      S_ALLOC: begin
        if (!rd_used_i) begin
          wr_o.en          = 1'b1;
          wr_o.used        = 1'b1;
          wr_o.idx         = ptr_q;
          wr_o.data.name   = name_q;
          wr_o.data.part   = j_q[IDX_W-1:0];
          wr_o.data.blocks = cnt_q;
          wr_o.data.link   = LINK_W'(ENTRIES);
          wr_o.data.fill   = fill;
          wr_o.lnk_en      = prev_vld_q;
          wr_o.lnk_idx     = prev_q;
          wr_o.lnk_val     = LINK_W'(ptr_q);
          res_d = mk_res(ST_OK, ptr_q, j_q[IDX_W-1:0], fill, cnt_q, free_q, files_q,
                         j_inc == cnt_q);
          res_vld_d  = 1'b1;
          left_d     = left_q - SIZE_W'(fill);
          j_d        = j_inc;
          prev_d     = ptr_q;
          prev_vld_d = 1'b1;
          if (j_inc == cnt_q) state_d = S_IDLE;
        end
        ptr_d = ptr_q + IDX_W'(1);
      end

      // head lookup for read and delete
      S_FIND: begin
        if (name_hit && (rd_i.part == '0)) begin
          head_d = ptr_q;
          cnt_d  = rd_i.blocks;
          if (rd_i.blocks == '0) begin
            state_d   = S_IDLE;
            res_vld_d = 1'b1;
            if (act_q == ACT_READ) begin
              res_d = mk_res(ST_OK, '0, '0, '0, '0, free_q, files_q, 1'b1);
            end else begin
              files_d = files_del;
              res_d   = mk_res(ST_OK, ptr_q, '0, '0, '0, free_q, files_del, 1'b1);
            end
          end else begin
            state_d = S_WALK;
          end
        end else if (ptr_q == LAST_IDX) begin
          res_d     = mk_res(ST_NOTFOUND, '0, '0, '0, '0, free_q, files_q, 1'b1);
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end

      // chain walk: report blocks, or free them
      S_WALK: begin
        if (act_q == ACT_READ) begin
          res_d = mk_res(ST_OK, ptr_q, rd_i.part, rd_i.fill, cnt_q, free_q, files_q,
                         walk_stop);
          res_vld_d = 1'b1;
        end else begin
          wr_o.en   = 1'b1;
          wr_o.used = 1'b0;
          wr_o.idx  = ptr_q;
          wr_o.data = ENT_RESET;
          freed_d   = freed_new;
          if (walk_stop) begin
            free_d    = free_del;
            files_d   = files_del;
            res_d     = mk_res(ST_OK, head_q, '0, '0, freed_new, free_del, files_del, 1'b1);
            res_vld_d = 1'b1;
          end
        end
        j_d   = j_inc;
        ptr_d = rd_i.link[IDX_W-1:0];
        if (walk_stop) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rd_idx_o    = ptr_q;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

/* hw/rtl/linked_block_allocation_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linked_block_allocation_table_unit: FAT-style block allocation table
// Keeps a chained table of fixed-size blocks and serves format, allocate,
// read-chain and delete requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_i) is taken at a rising edge with start_i high and busy_o
//   low. busy_o stays high until the request has produced its last result.
//   Results appear on res_o for one cycle each, flagged by res_valid_o, and
//   the final one of a request carries last. The receiver cannot stall.
// Request flow (entry pointer steps one table entry per cycle):
//   format   : result in the next cycle, busy_o stays low.
//   allocate : name scan over the whole table, then first-fit claims free
//              entries until all blocks are taken.
//   read     : head lookup, then one result per block.
//   delete   : head lookup, then each block of the chain is freed, then one result.
//   A request that is rejected ends at the cycle the fault is found.
//   Each result is registered before it shows on res_o.
// Reset: the table is empty (all blocks free, no files) right after reset;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module linked_block_allocation_table_unit (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  lbat_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output lbat_pkg::res_t  res_o
);
  import lbat_pkg::*;

  logic             clear;
  tbl_wr_t          tbl_wr;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_used;
  ent_t             rd_ent;

  // sequencer
  lbat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .clear_o     (clear),
    .wr_o        (tbl_wr),
    .rd_idx_o    (rd_idx),
    .rd_used_i   (rd_used),
    .rd_i        (rd_ent)
  );

  // table store
  lbat_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .wr_i      (tbl_wr),
    .rd_idx_i  (rd_idx),
    .rd_used_o (rd_used),
    .rd_o      (rd_ent)
  );

endmodule
`default_nettype wire

/* hw/rtl/lbat_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbat_checker: port-level checks for the allocation table
// Watches requests and results at the top level ports.
// ----------------------------------------------------------------------------
module lbat_checker (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  lbat_pkg::req_t  req_i,
  input  wire             busy_o,
  input  wire             res_valid_o,
  input  lbat_pkg::res_t  res_o
);
  import lbat_pkg::*;

  // an accepted request either runs or answers at once
  a_accept_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || res_valid_o))
    else $error("accepted request neither busy nor answered");

  // results that are not final come while the request is still running
  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy_o)
    else $error("non-final result while idle");

  // a failing request gives a single empty result
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |-> (res_o.last && (res_o.block_count == '0)))
    else $error("failing request gave a non-final or non-empty result");

  // counts never exceed the table
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((res_o.free_blocks <= CNT_W'(ENTRIES)) &&
                     (res_o.file_total <= CNT_W'(ENTRIES))))
    else $error("block or file count beyond table size");

endmodule

bind linked_block_allocation_table_unit lbat_checker u_lbat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .req_i       (req_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire

/* test/linked_block_allocation_table_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_block_allocation_table_unit_test: allocation table testbench
// Drives format, allocate, read-chain and delete requests into the table,
// keeps its own copy of the block table to predict every result, and checks
// each strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
module linked_block_allocation_table_unit_test;
  import lbat_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  // --------------------------------------------------------------------------
  // table shadow and expected-result store
  // --------------------------------------------------------------------------
  class lbat_scoreboard;
    bit               blk_used  [ENTRIES];
    logic [NAME_W-1:0] blk_owner [ENTRIES];
    int               blk_part  [ENTRIES];
    int               blk_count [ENTRIES];
    int               blk_size  [ENTRIES];
    int               blk_next  [ENTRIES];
    int               blk_fill  [ENTRIES];
    int               free_left;
    int               files_stored;
    res_t             expected_q[$];
    int               errors;
    int               results_seen;
    int               action_seen[4];

    function new();
      clear_table();
    endfunction

    function void clear_entry(int i);
      blk_used[i]  = 1'b0;
      blk_owner[i] = '0;
      blk_part[i]  = 0;
      blk_count[i] = 0;
      blk_size[i]  = 0;
      blk_next[i]  = ENTRIES;
      blk_fill[i]  = 0;
    endfunction

    function void clear_table();
      for (int i = 0; i < ENTRIES; i++) clear_entry(i);
      free_left    = ENTRIES;
      files_stored = 0;
    endfunction

    // result with the current free and file counts
    function res_t make_res(status_e st, int idx, int part, int bytes, int cnt, bit fin);
      res_t r;
      r.status         = st;
      r.block_index    = IDX_W'(idx);
      r.part_number    = IDX_W'(part);
      r.bytes_in_block = FILL_W'(bytes);
      r.block_count    = CNT_W'(cnt);
      r.free_blocks    = CNT_W'(free_left);
      r.file_total     = CNT_W'(files_stored);
      r.last           = fin;
      return r;
    endfunction

    // update the shadow table and queue the results one request causes
    function void note_request(req_t r);
      int need, left, fill, prev, part, head, k, nxt, freed, cnt;
      bit dup;
      action_seen[r.action]++;
      case (r.action)
        ACT_FORMAT: begin
          clear_table();
          expected_q.push_back(make_res(ST_OK, 0, 0, 0, 0, 1'b1));
        end
        ACT_ALLOCATE: begin
          dup = 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (blk_used[i] && blk_owner[i] == r.file_name) dup = 1'b1;
          need = (int'(r.file_size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
          if (need == 0) need = 1;   // empty file still takes a block
          if (dup) begin
            expected_q.push_back(make_res(ST_EXISTS, 0, 0, 0, 0, 1'b1));
          end else if (need > free_left || files_stored >= ENTRIES) begin
            expected_q.push_back(make_res(ST_NOSPACE, 0, 0, 0, 0, 1'b1));
          end else begin
            free_left    -= need;
            files_stored += 1;
            left = int'(r.file_size);
            prev = -1;
            part = 0;
            // first fit in index order, chained as we go
            for (int i = 0; i < ENTRIES && part < need; i++) begin
              if (blk_used[i]) continue;
              fill = (left >= BLOCK_BYTES) ? BLOCK_BYTES : left;
              left -= fill;
              blk_used[i]  = 1'b1;
              blk_owner[i] = r.file_name;
              blk_part[i]  = part;
              blk_count[i] = need;
              blk_size[i]  = int'(r.file_size);
              blk_fill[i]  = fill;
              blk_next[i]  = ENTRIES;
              if (prev >= 0) blk_next[prev] = i;
              expected_q.push_back(make_res(ST_OK, i, part, fill, need, part + 1 == need));
              prev = i;
              part++;
            end
          end
        end
        default: begin
          // lowest used head entry with this name
          head = ENTRIES;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (blk_used[i] && blk_part[i] == 0 && blk_owner[i] == r.file_name) head = i;
          if (head == ENTRIES) begin
            expected_q.push_back(make_res(ST_NOTFOUND, 0, 0, 0, 0, 1'b1));
          end else if (r.action == ACT_READ) begin
            cnt = blk_count[head];
            k   = head;
            for (int j = 0; j < cnt && k < ENTRIES; j++) begin
              expected_q.push_back(make_res(ST_OK, k, blk_part[k], blk_fill[k], cnt,
                                            !(j + 1 < cnt && blk_next[k] < ENTRIES)));
              k = blk_next[k];
            end
          end else begin
            cnt   = blk_count[head];
            k     = head;
            freed = 0;
            for (int j = 0; j < cnt && k < ENTRIES; j++) begin
              nxt = blk_next[k];
              if (blk_used[k]) freed++;
              clear_entry(k);
              k = nxt;
            end
            if (files_stored > 0) files_stored -= 1;
            free_left += freed;
            if (free_left > ENTRIES) free_left = ENTRIES;
            expected_q.push_back(make_res(ST_OK, head, 0, 0, freed, 1'b1));
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // compare one strobed result with the oldest expectation
    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with none pending (status %0d index %0d)",
                         results_seen, got.status, got.block_index));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, want %0d",
                         results_seen, got.status, want.status));
      if (got.block_index !== want.block_index)
        report($sformatf("result %0d block_index %0d, want %0d",
                         results_seen, got.block_index, want.block_index));
      if (got.part_number !== want.part_number)
        report($sformatf("result %0d part_number %0d, want %0d",
                         results_seen, got.part_number, want.part_number));
      if (got.bytes_in_block !== want.bytes_in_block)
        report($sformatf("result %0d bytes_in_block %0d, want %0d",
                         results_seen, got.bytes_in_block, want.bytes_in_block));
      if (got.block_count !== want.block_count)
        report($sformatf("result %0d block_count %0d, want %0d",
                         results_seen, got.block_count, want.block_count));
      if (got.free_blocks !== want.free_blocks)
        report($sformatf("result %0d free_blocks %0d, want %0d",
                         results_seen, got.free_blocks, want.free_blocks));
      if (got.file_total !== want.file_total)
        report($sformatf("result %0d file_total %0d, want %0d",
                         results_seen, got.file_total, want.file_total));
      if (got.last !== want.last)
        report($sformatf("result %0d last %0b, want %0b",
                         results_seen, got.last, want.last));
    endtask

    task finish_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_q.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  lbat_scoreboard sb;
  int unsigned    cycle_count;
  bit             no_gaps;
  int             name_pool[8];

  linked_block_allocation_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) sb.check_result(res_o);
  end

  // --------------------------------------------------------------------------
  // request drivers
  // --------------------------------------------------------------------------
  function automatic req_t make_req(action_e act, int name, int size);
    req_t r;
    r.action    = act;
    r.file_name = NAME_W'(name);
    r.file_size = SIZE_W'(size);
    return r;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 14);
  endfunction

  // mostly known names so that reads and deletes find files
  function automatic req_t random_request();
    int pick, name, size;
    action_e act;
    pick = $urandom_range(0, 99);
    if (pick < 3)       act = ACT_FORMAT;
    else if (pick < 45) act = ACT_ALLOCATE;
    else if (pick < 72) act = ACT_READ;
    else                act = ACT_DELETE;
    name = ($urandom_range(0, 99) < 85) ? name_pool[$urandom_range(0, 7)]
                                         : $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    if (pick < 10)      size = 0;
    else if (pick < 55) size = $urandom_range(1, 600);
    else if (pick < 80) size = $urandom_range(1, 2048);
    else if (pick < 95) size = $urandom_range(2049, 8192);
    else                size = $urandom_range(0, 16383);
    return make_req(act, name, size);
  endfunction

  // hold start and the request until taken, then book the request
  task automatic send_request(req_t r, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    req_i   = r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(r);
  endtask

  // sender stays quiet until every pending result is in
  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int base;
    sb          = new();
    cycle_count = 0;
    no_gaps     = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    foreach (name_pool[i]) name_pool[i] = $urandom_range(0, 255);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every action, duplicates, misses, fragmentation
    send_request(make_req(ACT_FORMAT, 0, 0), draw_gap());
    send_request(make_req(ACT_ALLOCATE, 0, 0), draw_gap());        // empty file
    send_request(make_req(ACT_ALLOCATE, 255, 16383), draw_gap());  // far too big
    send_request(make_req(ACT_ALLOCATE, 1, 256), draw_gap());
    send_request(make_req(ACT_ALLOCATE, 2, 257), draw_gap());
    send_request(make_req(ACT_ALLOCATE, 1, 10), draw_gap());       // name taken
    send_request(make_req(ACT_READ, 2, 0), draw_gap());
    send_request(make_req(ACT_READ, 77, 0), draw_gap());           // no such file
    send_request(make_req(ACT_DELETE, 1, 16383), draw_gap());
    send_request(make_req(ACT_ALLOCATE, 3, 700), draw_gap());      // split chain
    send_request(make_req(ACT_READ, 3, 0), draw_gap());
    send_request(make_req(ACT_DELETE, 9, 0), draw_gap());          // no such file
    send_request(make_req(ACT_READ, 0, 0), draw_gap());
    send_request(make_req(ACT_FORMAT, 170, 5461), draw_gap());
    send_request(make_req(ACT_ALLOCATE, 255, 8192), draw_gap());   // whole table
    send_request(make_req(ACT_READ, 255, 0), draw_gap());
    send_request(make_req(ACT_ALLOCATE, 4, 0), draw_gap());        // table full
    send_request(make_req(ACT_DELETE, 255, 0), draw_gap());
    send_request(make_req(ACT_ALLOCATE, 85, 10922), draw_gap());
    send_request(make_req(ACT_DELETE, 85, 0), draw_gap());
    wait_drained();

    // random traffic with gap-free stretches and occasional drains
    for (int n = 0; n < 160; n++) begin
      if (n % 25 == 0) no_gaps = (n % 50 != 0);
      if (n % 60 == 59) wait_drained();
      if (n == 110) begin
        // fill every slot with empty files, then one more than fits
        base = $urandom_range(0, 255);
        send_request(make_req(ACT_FORMAT, base, 0), draw_gap());
        for (int i = 0; i <= ENTRIES; i++)
          send_request(make_req(ACT_ALLOCATE, base + i, 0), draw_gap());
        send_request(make_req(ACT_READ, base + 5, 0), draw_gap());
        send_request(make_req(ACT_DELETE, base + 5, 0), draw_gap());
        send_request(make_req(ACT_ALLOCATE, base + 40, 300), draw_gap());
        send_request(make_req(ACT_ALLOCATE, base + 40, 1), draw_gap());
      end
      send_request(random_request(), draw_gap());
    end

    wait_drained();
    repeat (80) @(posedge clk_i);
    sb.finish_check();

    $display("covered %0d format, %0d allocate, %0d read and %0d delete requests",
             sb.action_seen[ACT_FORMAT], sb.action_seen[ACT_ALLOCATE],
             sb.action_seen[ACT_READ], sb.action_seen[ACT_DELETE]);
    $display("%0d results compared, %0d mismatches", sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* linked_block_allocation_table_unit.f */
hw/rtl/lbat_pkg.sv
hw/rtl/lbat_table.sv
hw/rtl/lbat_ctrl.sv
hw/rtl/linked_block_allocation_table_unit.sv
hw/rtl/lbat_checker.sv
test/linked_block_allocation_table_unit_test.sv
